// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks shared by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that cond never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: rtl/urxbf_pkg.sv
// ----------------------------------------------------------------------------
// urxbf_pkg
// Shared constants and types of the serial receiver with break detect and FIFO.
// ----------------------------------------------------------------------------
package urxbf_pkg;

	localparam int FIFO_DEPTH = 64;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = 7;

	localparam logic [3:0] STOP_INDEX = 4'd9;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_FLUSH = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [1:0] REG_SHIFT_TICKS = 2'd0;
	localparam logic [1:0] REG_BIT_TICKS   = 2'd1;
	localparam logic [1:0] REG_BREAK_TICKS = 2'd2;

	localparam logic [15:0] SHIFT_TICKS_RST = 16'd8;
	localparam logic [15:0] BIT_TICKS_RST   = 16'd16;
	localparam logic [23:0] BREAK_TICKS_RST = 24'd160;

	typedef struct packed {
		logic               en;
		logic [FIFO_AW-1:0] addr;
		logic [7:0]         data;
	} ram_wr_t;

endpackage

// File: rtl/urxbf_ram.sv
// ----------------------------------------------------------------------------
// urxbf_ram
// Receive FIFO storage: one write port, one registered read port with
// write-to-read bypass on an address match.
// ----------------------------------------------------------------------------
module urxbf_ram
	import urxbf_pkg::*;
(
	input  logic               clk,
	input  ram_wr_t            wr,
	input  logic [FIFO_AW-1:0] raddr,
	output logic [7:0]         rdata
);

	logic [7:0] mem_q [FIFO_DEPTH];
	logic [7:0] rd_q;
	logic [7:0] wdata_q;
	logic       byp_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_q    <= mem_q[raddr];
		wdata_q <= wr.data;
		byp_q   <= wr.en && (wr.addr == raddr);
	end

	assign rdata = byp_q ? wdata_q : rd_q;

endmodule

// File: rtl/uart_rx_break_fifo.sv
// ----------------------------------------------------------------------------
// uart_rx_break_fifo
// 8N1 serial receiver with break detect, error counting and a 64-byte FIFO.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel is one action (s_tuser): a line tick that
//   carries one receive-line sample in s_tdata[0], a pop, a flush or a clear.
//   Each request yields exactly one result on the m_ channel: popped byte,
//   pop flag (m_tuser), FIFO count, error count and the three status flags.
//   The request sits in the input register, then one pass of frame, FIFO and
//   flag logic loads the result register.
//   Throughput is one request per cycle while m_tready is high; the FIFO
//   head byte is prefetched from the storage read port at the next head
//   address, so pops run back to back.
//   When m_tready is low the result register holds and one more request is
//   taken into the input register; s_tready then drops until the result
//   drains. Reset empties both stages, loads the tick registers with 8, 16
//   and 160, idles the receiver with the break countdown armed, and empties
//   the FIFO. Write cfg_* only while no request is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uart_rx_break_fifo
	import urxbf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] line_level, [7:1] zero
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] read_data, [14:8] stored_count,
	                               // [22:15] error_count, [23] framing_flag,
	                               // [24] overrun_flag, [25] break_flag, [31:26] zero
	output logic        m_tuser,   // [0] read_valid
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logic [15:0] shift_ticks_q;
	logic [15:0] bit_ticks_q;
	logic [23:0] break_ticks_q;

	logic        valid_s1;
	logic [1:0]  action_s1;
	logic        level_s1;

	logic        rx_q, prev_q, armed_q;
	logic [23:0] ticks_q;
	logic [3:0]  idx_q;
	logic [7:0]  shift_q;
	logic [FIFO_AW-1:0] head_q;
	logic [CNT_W-1:0]   fill_q;
	logic [7:0]  err_q;
	logic        fr_q, ov_q, brk_q;

	logic        rx_d, prev_d, armed_d;
	logic [23:0] ticks_d;
	logic [3:0]  idx_d;
	logic [7:0]  shift_d;
	logic [FIFO_AW-1:0] head_d;
	logic [CNT_W-1:0]   fill_d;
	logic [7:0]  err_d;
	logic        fr_d, ov_d, brk_d;
	logic [7:0]  rdata_d;
	logic        rvalid_d;

	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_user_q;

	logic        advance, fire, expire;
	logic [2:0]  idx_m1;
	logic [FIFO_AW:0]   wsum;
	logic [FIFO_AW-1:0] waddr;
	logic [FIFO_AW-1:0] head_inc;
	logic [7:0]  head_data;
	ram_wr_t     wr;

	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_ticks_q <= SHIFT_TICKS_RST;
			bit_ticks_q   <= BIT_TICKS_RST;
			break_ticks_q <= BREAK_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHIFT_TICKS: shift_ticks_q <= cfg_data[15:0];
				REG_BIT_TICKS:   bit_ticks_q   <= cfg_data[15:0];
				REG_BREAK_TICKS: break_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			level_s1  <= s_tdata[0];
		end
	end

	assign expire   = (ticks_q <= 24'd1);
	assign idx_m1   = idx_q[2:0] - 3'd1;
	assign wsum     = {1'b0, head_q} + {1'b0, fill_q[FIFO_AW-1:0]};
	assign waddr    = (wsum >= (FIFO_AW+1)'(FIFO_DEPTH))
		? FIFO_AW'(wsum - (FIFO_AW+1)'(FIFO_DEPTH)) : wsum[FIFO_AW-1:0];
	assign head_inc = (head_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;

	always_comb begin
		rx_d     = rx_q;
		prev_d   = prev_q;
		armed_d  = armed_q;
		ticks_d  = ticks_q;
		idx_d    = idx_q;
		shift_d  = shift_q;
		head_d   = head_q;
		fill_d   = fill_q;
		err_d    = err_q;
		fr_d     = fr_q;
		ov_d     = ov_q;
		brk_d    = brk_q;
		rdata_d  = 8'd0;
		rvalid_d = 1'b0;
		wr.en    = 1'b0;
		wr.addr  = waddr;
		wr.data  = shift_q;
		if (fire) begin
			case (action_s1)
				ACT_TICK: begin
					prev_d = level_s1;
					if (!rx_q) begin
						if (prev_q && !level_s1) begin
							rx_d    = 1'b1;
							brk_d   = 1'b0;
							shift_d = 8'd0;
							idx_d   = 4'd0;
							ticks_d = {8'd0, shift_ticks_q};
						end else if (armed_q) begin
							if (expire) begin
								ticks_d = 24'd0;
								brk_d   = 1'b1;
								armed_d = 1'b0;
							end else begin
								ticks_d = ticks_q - 24'd1;
							end
						end
					end else if (!expire) begin
						ticks_d = ticks_q - 24'd1;
					end else begin
						ticks_d = 24'd0;
						if (idx_q == 4'd0) begin
							if (level_s1) begin
								err_d   = err_q + 8'd1;
								fr_d    = 1'b1;
								rx_d    = 1'b0;
								ticks_d = break_ticks_q;
								armed_d = 1'b1;
							end else begin
								idx_d   = 4'd1;
								ticks_d = {8'd0, bit_ticks_q};
							end
						end else if (idx_q < STOP_INDEX) begin
							shift_d = shift_q | ({7'd0, level_s1} << idx_m1);
							idx_d   = idx_q + 4'd1;
							ticks_d = {8'd0, bit_ticks_q};
						end else begin
							if (!level_s1) begin
								err_d = err_q + 8'd1;
								fr_d  = 1'b1;
							end else if (fill_q < CNT_W'(FIFO_DEPTH)) begin
								wr.en  = 1'b1;
								fill_d = fill_q + 1'b1;
							end else begin
								err_d = err_q + 8'd1;
								ov_d  = 1'b1;
							end
							rx_d    = 1'b0;
							ticks_d = break_ticks_q;
							armed_d = 1'b1;
						end
					end
				end
				ACT_POP: begin
					if (fill_q != '0) begin
						rdata_d  = head_data;
						rvalid_d = 1'b1;
						head_d   = head_inc;
						fill_d   = fill_q - 1'b1;
						ov_d     = 1'b0;
					end
				end
				ACT_FLUSH: begin
					ov_d   = 1'b0;
					fill_d = '0;
					head_d = '0;
				end
				default: begin
					fr_d   = 1'b0;
					ov_d   = 1'b0;
					fill_d = '0;
					head_d = '0;
					err_d  = 8'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q    <= 1'b0;
			prev_q  <= 1'b1;
			armed_q <= 1'b1;
			ticks_q <= BREAK_TICKS_RST;
			idx_q   <= 4'd0;
			shift_q <= 8'd0;
			head_q  <= '0;
			fill_q  <= '0;
			err_q   <= 8'd0;
			fr_q    <= 1'b0;
			ov_q    <= 1'b0;
			brk_q   <= 1'b0;
		end else begin
			rx_q    <= rx_d;
			prev_q  <= prev_d;
			armed_q <= armed_d;
			ticks_q <= ticks_d;
			idx_q   <= idx_d;
			shift_q <= shift_d;
			head_q  <= head_d;
			fill_q  <= fill_d;
			err_q   <= err_d;
			fr_q    <= fr_d;
			ov_q    <= ov_d;
			brk_q   <= brk_d;
		end
	end

	urxbf_ram u_ram (
		.clk   (clk),
		.wr    (wr),
		.raddr (head_d),
		.rdata (head_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {6'd0, brk_d, ov_d, fr_d, err_d, fill_d, rdata_d};
			out_user_q <= rvalid_d;
		end
	end

	`ASSERT_NEVER(a_fill_bound, fill_q > CNT_W'(FIFO_DEPTH), "FIFO fill above depth")
	`ASSERT_NEVER(a_index_bound, rx_q && (idx_q > STOP_INDEX), "bit index past stop bit")
	`ASSERT_CLK(a_idle_on_fire, $fell(rx_q) |-> $past(fire), "receiver left frame without a request")

endmodule
